/* rtl/ndpf_pkg.sv */
// ----------------------------------------------------------------------------
// ndpf_pkg
// Shared types, widths and helpers of the near-duplicate point filter.
// ----------------------------------------------------------------------------
package ndpf_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 24;
	localparam int THR_W      = 23;
	localparam int ABS_W      = COORD_W + 1;
	localparam int PROD_W     = 2 * ABS_W;
	localparam int THR2_W     = 2 * THR_W;
	localparam int SLOT_W     = 10;

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef struct packed {
		logic load;
		logic add;
	} sq_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_THR,
		ST_THR_LD,
		ST_RD,
		ST_SX,
		ST_SY,
		ST_SZ,
		ST_SA,
		ST_NEW,
		ST_RES
	} state_t;

	function automatic logic [ABS_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b);
		logic signed [ABS_W-1:0] d;
		d = ABS_W'(a) - ABS_W'(b);
		abs_diff = d[ABS_W-1] ? ABS_W'(-d) : ABS_W'(d);
	endfunction

endpackage

/* rtl/near_duplicate_point_filter_core.sv */
// ----------------------------------------------------------------------------
// near_duplicate_point_filter_core
// Point deduplication against a store of unique points by squared distance.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  tdata x,y,z; tuser start_new_set
//   m_*      out        m_tvalid/m_tready  tdata slot_index; tuser flags
//   cfg_*    in         cfg_valid/ready    merge_threshold
//
// Each stored point compared costs one memory read, three passes of the
// shared squaring unit and one compare. The block accepts one word at a
// time and is busy until its result is loaded into the output register.
// The reset clears the store count and sets the threshold to one; the
// store itself needs no clearing. A stalled output holds the result and
// the next word may still be accepted meanwhile.
// ----------------------------------------------------------------------------
module near_duplicate_point_filter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // coord_x, coord_y, coord_z
	input  logic        s_tuser,   // start_new_set
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // slot_index, zero padding
	output logic [1:0]  m_tuser,   // is_unique, store_full
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [ndpf_pkg::THR_W-1:0] cfg_data
);
	import ndpf_pkg::*;

	state_t state_q, state_d;

	point_t              pt_q;
	logic [THR_W-1:0]    thr_q;
	logic [THR2_W-1:0]   thr2_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    i_q;
	logic                res_unique_q, res_full_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic                m_tvalid_q;
	logic [SLOT_W-1:0]   m_slot_q;
	logic                m_unique_q, m_full_q;

	logic                ram_wr_en, ram_rd_en;
	point_t              ram_rd_data;
	logic [ABS_W-1:0]    sq_op;
	sq_ctl_t             sq_ctl;
	logic [PROD_W-1:0]   sq_prod, sq_sum;
	logic                s_accept, is_match, is_last, is_full, out_load;

	ndpf_point_ram u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (IDX_W'(count_q)),
		.wr_data (pt_q),
		.rd_en   (ram_rd_en),
		.rd_addr (i_q),
		.rd_data (ram_rd_data)
	);

	ndpf_sq_unit u_sq (
		.clk  (clk),
		.op   (sq_op),
		.ctl  (sq_ctl),
		.prod (sq_prod),
		.sum  (sq_sum)
	);

	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign is_match  = sq_sum < PROD_W'(thr2_q);
	assign is_last   = (CNT_W'(i_q) + CNT_W'(1)) == count_q;
	assign is_full   = count_q == CNT_W'(MAX_POINTS);
	assign out_load  = (state_q == ST_RES) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ram_rd_en = 1'b0;
		ram_wr_en = 1'b0;
		sq_op     = '0;
		sq_ctl    = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_THR;
				end
			end
			ST_THR: begin
				sq_op   = ABS_W'(thr_q);
				state_d = ST_THR_LD;
			end
			ST_THR_LD: begin
				state_d = (count_q == '0) ? ST_NEW : ST_RD;
			end
			ST_RD: begin
				ram_rd_en = 1'b1;
				state_d   = ST_SX;
			end
			ST_SX: begin
				sq_op   = abs_diff(pt_q.x, ram_rd_data.x);
				state_d = ST_SY;
			end
			ST_SY: begin
				sq_op       = abs_diff(pt_q.y, ram_rd_data.y);
				sq_ctl.load = 1'b1;
				state_d     = ST_SZ;
			end
			ST_SZ: begin
				sq_op      = abs_diff(pt_q.z, ram_rd_data.z);
				sq_ctl.add = 1'b1;
				state_d    = ST_SA;
			end
			ST_SA: begin
				if (is_match) begin
					state_d = ST_RES;
				end else if (is_last) begin
					state_d = ST_NEW;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_NEW: begin
				ram_wr_en = !is_full;
				state_d   = ST_RES;
			end
			ST_RES: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= THR_W'(1);
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			if (s_accept && s_tuser) begin
				count_q <= '0;
			end else if (ram_wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			pt_q <= point_t'(s_tdata);
		end
		if (state_q == ST_THR_LD) begin
			thr2_q <= sq_prod[THR2_W-1:0];
			i_q    <= '0;
		end
		if (state_q == ST_SA) begin
			if (is_match) begin
				res_unique_q <= 1'b0;
				res_full_q   <= 1'b0;
				res_slot_q   <= SLOT_W'(i_q);
			end else if (!is_last) begin
				i_q <= i_q + IDX_W'(1);
			end
		end
		if (state_q == ST_NEW) begin
			res_unique_q <= 1'b1;
			res_full_q   <= is_full;
			res_slot_q   <= is_full ? '0 : SLOT_W'(count_q);
		end
		if (out_load) begin
			m_slot_q   <= res_slot_q;
			m_unique_q <= res_unique_q;
			m_full_q   <= res_full_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = 16'(m_slot_q);
	assign m_tuser  = {m_full_q, m_unique_q};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("store count beyond depth");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> !is_full)
		else $error("store write while full");
	a_dup_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> !m_tuser[1])
		else $error("duplicate flagged as store full");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_tready)
		else $error("ready right after acceptance");
`endif

endmodule

/* rtl/ndpf_point_ram.sv */
// ----------------------------------------------------------------------------
// ndpf_point_ram
// Store of unique points: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ndpf_point_ram (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [ndpf_pkg::IDX_W-1:0] wr_addr,
	input  ndpf_pkg::point_t      wr_data,
	input  logic                  rd_en,
	input  logic [ndpf_pkg::IDX_W-1:0] rd_addr,
	output ndpf_pkg::point_t      rd_data
);
	import ndpf_pkg::*;

	point_t mem [MAX_POINTS];
	point_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/ndpf_sq_unit.sv */
// ----------------------------------------------------------------------------
// ndpf_sq_unit
// Shared squaring unit with accumulator, used for the squared threshold and
// for the three axis terms of each squared distance.
// ----------------------------------------------------------------------------
module ndpf_sq_unit (
	input  logic                        clk,
	input  logic [ndpf_pkg::ABS_W-1:0]  op,
	input  ndpf_pkg::sq_ctl_t           ctl,
	output logic [ndpf_pkg::PROD_W-1:0] prod,
	output logic [ndpf_pkg::PROD_W-1:0] sum
);
	import ndpf_pkg::*;

	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op) * PROD_W'(op);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= prod_q;
		end else if (ctl.add) begin
			acc_q <= acc_q + prod_q;
		end
	end

	assign prod = prod_q;
	assign sum  = acc_q + prod_q;

endmodule

/* test/tb_near_duplicate_point_filter_core.sv */
// ----------------------------------------------------------------------------
// tb_near_duplicate_point_filter_core
// Self-checking testbench of the near-duplicate point filter core.
//
// Points are sent as stream words and the result of each one is predicted
// when the word is accepted. The prediction keeps its own store of unique
// points and its own threshold, and compares squared distances at full
// width. Every result word is checked field by field against the oldest
// prediction. The run starts with directed points at the threshold
// boundaries and the coordinate extremes. It then continues with random
// sets of clustered, copied and fresh points under several thresholds.
// Both sides pause at random, except in the final phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_near_duplicate_point_filter_core;

	import ndpf_pkg::*;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
	localparam logic [THR_W-1:0]          LIMIT_MAX = 23'h7FFFFF;
	localparam int                        CYCLE_LIMIT = 10_000_000;
	localparam int                        PHASE_WORDS = 70;

	typedef struct {
		logic   start;
		point_t pt;
	} point_word_t;

	typedef struct {
		logic              is_unique;
		logic [SLOT_W-1:0] slot_index;
		logic              store_full;
	} verdict_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [71:0]       s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;
	logic [1:0]        m_tuser;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [THR_W-1:0]  cfg_data = '0;

	point_word_t       point_queue[$];
	verdict_t          verdict_queue[$];

	point_t            kept_points[MAX_POINTS];
	int                kept_count = 0;
	logic [THR_W-1:0]  merge_limit = 23'd1;

	int                words_queued = 0;
	int                words_sent = 0;
	int                fail_count = 0;
	int                cycle_count = 0;
	int                src_gap = 0;
	int                sink_gap = 0;
	bit                idle_on = 1'b1;
	logic              in_taken = 1'b0;
	logic              cfg_taken = 1'b0;

	near_duplicate_point_filter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	task automatic predict_dedup(input logic start, input point_t p, output verdict_t v);
		longint          dx;
		longint          dy;
		longint          dz;
		longint unsigned dist2;
		longint unsigned limit2;
		bit              hit;
		if (start) begin
			kept_count = 0;
		end
		limit2 = longint'(merge_limit) * longint'(merge_limit);
		v.is_unique  = 1'b1;
		v.slot_index = '0;
		v.store_full = 1'b0;
		hit = 1'b0;
		for (int i = 0; i < kept_count && !hit; i++) begin
			dx = longint'($signed(p.x)) - longint'($signed(kept_points[i].x));
			dy = longint'($signed(p.y)) - longint'($signed(kept_points[i].y));
			dz = longint'($signed(p.z)) - longint'($signed(kept_points[i].z));
			dist2 = dx * dx + dy * dy + dz * dz;
			if (dist2 < limit2) begin
				hit = 1'b1;
				v.is_unique  = 1'b0;
				v.slot_index = SLOT_W'(i);
			end
		end
		if (!hit) begin
			if (kept_count >= MAX_POINTS) begin
				v.store_full = 1'b1;
			end else begin
				kept_points[kept_count] = p;
				v.slot_index = SLOT_W'(kept_count);
				kept_count++;
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (src_gap > 0) begin
					s_tvalid <= 1'b0;
					src_gap--;
				end else if (point_queue.size() > 0) begin
					point_word_t w;
					w = point_queue.pop_front();
					s_tdata  <= w.pt;
					s_tuser  <= w.start;
					s_tvalid <= 1'b1;
					if (idle_on && $urandom_range(0, 9) == 0) begin
						src_gap = $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (sink_gap > 0) begin
				m_tready <= 1'b0;
				sink_gap--;
			end else begin
				m_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0) begin
					sink_gap = $urandom_range(1, 8);
				end
			end
		end
	end

	always @(posedge clk) begin
		verdict_t v;
		verdict_t got;
		if (arst_n) begin
			in_taken  <= s_tvalid && s_tready;
			cfg_taken <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) begin
				merge_limit = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				predict_dedup(s_tuser, point_t'(s_tdata), v);
				verdict_queue.push_back(v);
				words_sent++;
			end
			if (m_tvalid && m_tready) begin
				got.is_unique  = m_tuser[0];
				got.store_full = m_tuser[1];
				got.slot_index = m_tdata[SLOT_W-1:0];
				if (verdict_queue.size() == 0) begin
					$error("result word with no prediction waiting");
					fail_count++;
				end else begin
					v = verdict_queue.pop_front();
					if (got.is_unique !== v.is_unique) begin
						$error("is_unique: expected %0d, actual %0d", v.is_unique,
							got.is_unique);
						fail_count++;
					end
					if (got.slot_index !== v.slot_index) begin
						$error("slot_index: expected %0d, actual %0d", v.slot_index,
							got.slot_index);
						fail_count++;
					end
					if (got.store_full !== v.store_full) begin
						$error("store_full: expected %0d, actual %0d", v.store_full,
							got.store_full);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic point_t make_point(input int x, input int y, input int z);
		point_t p;
		p.x = COORD_W'(x);
		p.y = COORD_W'(y);
		p.z = COORD_W'(z);
		return p;
	endfunction

	function automatic point_t random_point();
		point_t p;
		p.x = COORD_W'($urandom);
		p.y = COORD_W'($urandom);
		p.z = COORD_W'($urandom);
		return p;
	endfunction

	function automatic point_t near_point(input point_t b, input int span);
		point_t p;
		int     dx;
		int     dy;
		int     dz;
		dx = int'($urandom_range(0, 2 * span)) - span;
		dy = int'($urandom_range(0, 2 * span)) - span;
		dz = int'($urandom_range(0, 2 * span)) - span;
		p.x = b.x + COORD_W'(dx);
		p.y = b.y + COORD_W'(dy);
		p.z = b.z + COORD_W'(dz);
		return p;
	endfunction

	task automatic queue_point(input logic start, input point_t p);
		point_word_t w;
		w.start = start;
		w.pt    = p;
		point_queue.push_back(w);
		words_queued++;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (words_sent != words_queued || verdict_queue.size() != 0);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random_phase(input logic [THR_W-1:0] limit);
		point_t set_points[$];
		point_t p;
		int     span;
		int     set_len;
		int     sent;
		int     pick;
		write_threshold(limit);
		span = (limit > 4000) ? 4000 : int'(limit) + 2;
		sent = 0;
		while (sent < PHASE_WORDS) begin
			set_points.delete();
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 24);
			if (set_len > PHASE_WORDS - sent) begin
				set_len = PHASE_WORDS - sent;
			end
			for (int k = 0; k < set_len; k++) begin
				pick = $urandom_range(0, 99);
				if (set_points.size() == 0 || pick < 35) begin
					p = random_point();
				end else if (pick < 55) begin
					p = set_points[$urandom_range(0, set_points.size() - 1)];
				end else if (pick < 90) begin
					p = near_point(set_points[$urandom_range(0, set_points.size() - 1)],
						span);
				end else begin
					p = near_point(set_points[set_points.size() - 1], 4 * span);
				end
				set_points.push_back(p);
				queue_point(k == 0, p);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_point(1'b1, make_point(0, 0, 0));
		queue_point(1'b0, make_point(0, 0, 0));
		queue_point(1'b0, make_point(1, 0, 0));
		queue_point(1'b0, '{x: COORD_MAX, y: COORD_MAX, z: COORD_MAX});
		queue_point(1'b0, '{x: COORD_MIN, y: COORD_MIN, z: COORD_MIN});
		queue_point(1'b0, '{x: COORD_MIN, y: COORD_MAX, z: COORD_MIN});
		queue_point(1'b0, '{x: COORD_MAX, y: COORD_MIN, z: COORD_MAX});
		queue_point(1'b0, '{x: COORD_MIN, y: COORD_MIN, z: COORD_MIN});
		queue_point(1'b1, '{x: COORD_MIN, y: COORD_MIN, z: COORD_MIN});

		write_threshold(23'd5);
		queue_point(1'b1, make_point(0, 0, 0));
		queue_point(1'b0, make_point(3, 4, 0));
		queue_point(1'b0, make_point(-3, -3, 0));
		queue_point(1'b0, make_point(3, 4, -1));
		queue_point(1'b0, make_point(2, 2, 0));

		write_threshold(23'd0);
		queue_point(1'b1, make_point(7, -7, 7));
		queue_point(1'b0, make_point(7, -7, 7));

		write_threshold(LIMIT_MAX);
		queue_point(1'b1, '{x: COORD_MIN, y: COORD_MIN, z: COORD_MIN});
		queue_point(1'b0, '{x: COORD_MAX, y: COORD_MAX, z: COORD_MAX});
		queue_point(1'b0, make_point(0, 0, 0));
		queue_point(1'b0, make_point(1, -1, 1));
		queue_point(1'b0, '{x: COORD_MAX, y: COORD_MIN, z: 24'sd0});

		for (int k = 0; k < 3; k++) begin
			queue_point(1'b0, random_point());
		end

		run_random_phase(23'd1);
		run_random_phase(23'd0);
		run_random_phase(LIMIT_MAX);
		run_random_phase(THR_W'($urandom_range(2, 64)));
		run_random_phase(THR_W'($urandom_range(64, 4096)));
		run_random_phase(THR_W'($urandom));
		run_random_phase(THR_W'($urandom_range(1, 300)));
		wait_drained();
		idle_on = 1'b0;
		run_random_phase(THR_W'($urandom_range(2, 1000)));

		wait_drained();
		repeat (40) @(negedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* near_duplicate_point_filter_core.f */
rtl/ndpf_pkg.sv
rtl/ndpf_point_ram.sv
rtl/ndpf_sq_unit.sv
rtl/near_duplicate_point_filter_core.sv
test/tb_near_duplicate_point_filter_core.sv
